// ===== hdl/tct_pkg.sv =====
// Shared types and constants for the track confirmation table.
`default_nettype none
package tct_pkg;

  localparam int KEY_W     = 32;
  localparam int TIME_W    = 32;
  localparam int HIT_W     = 4;
  localparam int MIN_W     = 16;
  localparam int EXP_W     = 20;
  localparam int EVICT_W   = 6;
  localparam int MOD_SLOTS = 4;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 48;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HITS0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HITS1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HITS2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HITS3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY    = 3'd4;

  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_SWEEP   = 1'b1;

  localparam logic [MIN_W-1:0] MIN_HITS0_RST = 16'd1;
  localparam logic [EXP_W-1:0] EXPIRY_RST    = 20'd5000;

  typedef struct packed {
    logic match;
    logic stale;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== hdl/tct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/tct_cmp_unit.sv =====
// Shared compare unit: key match and staleness test for one table entry.
`default_nettype none
module tct_cmp_unit (
  input  wire logic [tct_pkg::KEY_W-1:0]  key,
  input  wire logic [tct_pkg::KEY_W-1:0]  entry_key,
  input  wire logic [tct_pkg::TIME_W-1:0] now,
  input  wire logic [tct_pkg::TIME_W-1:0] seen,
  input  wire logic [tct_pkg::EXP_W-1:0]  expiry,
  output tct_pkg::cmp_res_t               res
);

  logic [tct_pkg::TIME_W-1:0] age;

  assign age = now - seen;

  // Evict when seen lies in the future or the age runs past the timeout.
  always_comb begin
    res.match = (key == entry_key);
    res.stale = (now < seen) || (age > tct_pkg::TIME_W'(expiry));
  end

endmodule
`default_nettype wire

// ===== hdl/tct_count_upd.sv =====
// Saturating per-modality counter update and minimum-hits check.
`default_nettype none
module tct_count_upd #(
  parameter int MODALITIES = 4,
  parameter int COUNT_BITS = 16
) (
  input  wire logic [MODALITIES*COUNT_BITS-1:0]             counts_old,
  input  wire logic [tct_pkg::MOD_SLOTS*tct_pkg::HIT_W-1:0] hits,
  input  wire logic [tct_pkg::MOD_SLOTS*tct_pkg::MIN_W-1:0] min_hits,
  output logic      [MODALITIES*COUNT_BITS-1:0]             counts_new,
  output logic                                              all_met
);

  logic [MODALITIES-1:0] met;

  for (genvar m = 0; m < MODALITIES; m++) begin : g_mod
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] sat;

    assign sum = {1'b0, counts_old[m*COUNT_BITS +: COUNT_BITS]}
               + (COUNT_BITS+1)'(hits[m*tct_pkg::HIT_W +: tct_pkg::HIT_W]);
    assign sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    assign counts_new[m*COUNT_BITS +: COUNT_BITS] = sat;
    assign met[m] = (32'(sat) >= 32'(min_hits[m*tct_pkg::MIN_W +: tct_pkg::MIN_W]));
  end

  assign all_met = &met;

endmodule
`default_nettype wire

// ===== hdl/track_confirmation_table.sv =====
// Track confirmation table: each beat passes the scan, which walks one entry per cycle
// through the shared compare unit, then the select state; an observe that lands on an
// entry also passes the update state before the done state registers its result beat,
// while a sweep or full-table reject goes from select straight to done. One item at a
// time: the next beat is taken once the result has moved to the output register, even while it still waits there.
// Reset clears valid and confirmed marks and loads register defaults; RAMs are not cleared.
`default_nettype none
module track_confirmation_table #(
  parameter int TABLE_ENTRIES = 32,
  parameter int MODALITIES    = 4,
  parameter int COUNT_BITS    = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // track_key, has_composite, hits_mod0..3, now_ms, zero pad
  input  wire logic [tct_pkg::S_TDATA_W-1:0]       s_tdata,
  // action
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // out_key, forward, newly_confirmed, table_full, evicted_count, zero pad
  output logic      [tct_pkg::M_TDATA_W-1:0]       m_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tct_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [tct_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = MODALITIES * COUNT_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  // configuration
  logic [tct_pkg::MOD_SLOTS*tct_pkg::MIN_W-1:0] min_hits;
  logic [tct_pkg::EXP_W-1:0]                    expiry;

  // latched item
  logic                                         act;
  logic [tct_pkg::KEY_W-1:0]                    key;
  logic                                         has_comp;
  logic [tct_pkg::MOD_SLOTS*tct_pkg::HIT_W-1:0] hits;
  logic [tct_pkg::TIME_W-1:0]                   now;

  // table marks
  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [TABLE_ENTRIES-1:0] slot_confirmed;

  // scan control
  logic [IDX_W-1:0] scan_idx;
  logic             issue_on;
  logic             pend;
  logic [IDX_W-1:0] pidx;
  logic             found;
  logic [IDX_W-1:0] found_slot;
  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] cur_slot;
  logic             is_new;
  logic [tct_pkg::EVICT_W-1:0] evicted;

  // result
  logic                        res_fwd;
  logic                        res_newly;
  logic                        res_full;
  logic [tct_pkg::KEY_W-1:0]   res_key;
  logic [tct_pkg::EVICT_W-1:0] res_evicted;

  // RAM ports
  logic [tct_pkg::KEY_W-1:0]  key_rdata;
  logic [tct_pkg::TIME_W-1:0] seen_rdata;
  logic [CNT_W-1:0]           cnt_rdata;
  logic [IDX_W-1:0]           cnt_raddr;
  logic                       key_we;
  logic                       cnt_we;
  logic                       seen_we;
  logic [CNT_W-1:0]           cnt_wdata;

  tct_pkg::cmp_res_t cmp;
  logic [CNT_W-1:0]  counts_old;
  logic [CNT_W-1:0]  counts_new;
  logic              all_met;
  logic              conf_old;
  logic              do_count;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  tct_ram #(.WIDTH(tct_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(cur_slot), .wdata(key),
    .raddr(scan_idx), .rdata(key_rdata)
  );

  tct_ram #(.WIDTH(tct_pkg::TIME_W), .DEPTH(TABLE_ENTRIES)) u_seen_ram (
    .clk(clk), .we(seen_we), .waddr(cur_slot), .wdata(now),
    .raddr(scan_idx), .rdata(seen_rdata)
  );

  tct_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cur_slot), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  tct_cmp_unit u_cmp (
    .key(key), .entry_key(key_rdata), .now(now), .seen(seen_rdata),
    .expiry(expiry), .res(cmp)
  );

  tct_count_upd #(.MODALITIES(MODALITIES), .COUNT_BITS(COUNT_BITS)) u_upd (
    .counts_old(counts_old), .hits(hits), .min_hits(min_hits),
    .counts_new(counts_new), .all_met(all_met)
  );

  always_comb begin
    cnt_raddr  = found ? found_slot : free_slot;
    counts_old = is_new ? '0 : cnt_rdata;
    conf_old   = !is_new && slot_confirmed[cur_slot];
    do_count   = !conf_old && has_comp;
    key_we     = (state == S_UPD) && is_new;
    seen_we    = (state == S_UPD);
    cnt_we     = (state == S_UPD) && (is_new || do_count);
    cnt_wdata  = do_count ? counts_new : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      slot_confirmed <= '0;
      m_tvalid       <= 1'b0;
      issue_on       <= 1'b0;
      pend           <= 1'b0;
      min_hits       <= {16'd0, 16'd0, 16'd0, tct_pkg::MIN_HITS0_RST};
      expiry         <= tct_pkg::EXPIRY_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tct_pkg::CFG_MIN_HITS0: min_hits[0*tct_pkg::MIN_W +: tct_pkg::MIN_W] <= cfg_data[15:0];
          tct_pkg::CFG_MIN_HITS1: min_hits[1*tct_pkg::MIN_W +: tct_pkg::MIN_W] <= cfg_data[15:0];
          tct_pkg::CFG_MIN_HITS2: min_hits[2*tct_pkg::MIN_W +: tct_pkg::MIN_W] <= cfg_data[15:0];
          tct_pkg::CFG_MIN_HITS3: min_hits[3*tct_pkg::MIN_W +: tct_pkg::MIN_W] <= cfg_data[15:0];
          tct_pkg::CFG_EXPIRY:    expiry <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= s_tuser;
            key        <= s_tdata[31:0];
            has_comp   <= s_tdata[32];
            hits       <= s_tdata[48:33];
            now        <= s_tdata[80:49];
            scan_idx   <= '0;
            issue_on   <= 1'b1;
            pend       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            evicted    <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue stops in the cycle before the last pending compare, so pend drops by itself
          pend <= issue_on;
          pidx <= scan_idx;
          if (issue_on) begin
            if (scan_idx == LAST_IDX) begin
              issue_on <= 1'b0;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (pend) begin
            if (act == tct_pkg::ACT_SWEEP) begin
              if (slot_valid[pidx] && cmp.stale) begin
                slot_valid[pidx]     <= 1'b0;
                slot_confirmed[pidx] <= 1'b0;
                evicted              <= evicted + 1'b1;
              end
            end else begin
              if (slot_valid[pidx] && cmp.match && !found) begin
                found      <= 1'b1;
                found_slot <= pidx;
              end
              if (!slot_valid[pidx] && !free_found) begin
                free_found <= 1'b1;
                free_slot  <= pidx;
              end
            end
            if (pidx == LAST_IDX) begin
              state <= S_SEL;
            end
          end
        end
        S_SEL: begin
          res_fwd   <= 1'b0;
          res_newly <= 1'b0;
          if (act == tct_pkg::ACT_SWEEP) begin
            res_key     <= '0;
            res_full    <= 1'b0;
            res_evicted <= evicted;
            state       <= S_DONE;
          end else begin
            res_key     <= key;
            res_evicted <= '0;
            if (!found && !free_found) begin
              res_full <= 1'b1;
              state    <= S_DONE;
            end else begin
              // count RAM read is issued at cnt_raddr this cycle
              res_full <= 1'b0;
              cur_slot <= cnt_raddr;
              is_new   <= !found;
              state    <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (is_new) begin
            slot_valid[cur_slot] <= 1'b1;
          end
          slot_confirmed[cur_slot] <= conf_old || (has_comp && all_met);
          if (conf_old) begin
            res_fwd <= 1'b1;
          end else if (has_comp && all_met) begin
            res_fwd   <= 1'b1;
            res_newly <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register frees up
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_evicted, res_full, res_newly, res_fwd, res_key};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tct_checker.sv =====
// Port-level checks for the track confirmation table, bound to the top level.
`default_nettype none
module tct_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [tct_pkg::M_TDATA_W-1:0] m_tdata
);

  // one item at a time: ready drops right after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

  a_sweep_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[40:35] != 6'd0)) |-> (m_tdata[34:0] == 35'd0))
    else $error("sweep result carries observe fields");

  a_newly_fwd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33]) |-> (m_tdata[32] && !m_tdata[34]))
    else $error("newly confirmed without forward");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34]) |-> !m_tdata[32])
    else $error("forwarded with full table");

endmodule

bind track_confirmation_table tct_checker u_tct_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== tb/tb_track_confirmation_table.sv =====
// Self-checking testbench for the track confirmation table.
`timescale 1ns / 1ps
module tb_track_confirmation_table;

  localparam int          ENTRIES     = 32;
  localparam int          SCAN_CYCLES = ENTRIES + 4;
  localparam int          CYCLE_LIMIT = 1500000;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  // indexes past the register file; writes to them must do nothing
  localparam logic [tct_pkg::CFG_INDEX_W-1:0] CFG_SPARE5 = 3'd5;
  localparam logic [tct_pkg::CFG_INDEX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [tct_pkg::CFG_INDEX_W-1:0] CFG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] key;
    logic        fwd;
    logic        newc;
    logic        full;
    logic [5:0]  evicted;
  } track_result_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  // track_key, has_composite, hits_mod0..3, now_ms, zero pad
  logic [tct_pkg::S_TDATA_W-1:0]   s_tdata;
  // action
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  // out_key, forward, newly_confirmed, table_full, evicted_count, zero pad
  logic [tct_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tct_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tct_pkg::CFG_DATA_W-1:0]  cfg_data;

  track_confirmation_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted table and registers
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key   [ENTRIES];
  logic [15:0] tbl_cnt   [ENTRIES][tct_pkg::MOD_SLOTS];
  logic        tbl_conf  [ENTRIES];
  logic [31:0] tbl_seen  [ENTRIES];
  logic [15:0] min_req   [tct_pkg::MOD_SLOTS];
  logic [19:0] expiry_lim;

  track_result_t pending_results[$];
  logic [31:0]   clock_now;
  bit            no_idle;
  int            fail_count;
  int            items_sent;
  int            results_seen;
  int            confirms_seen;
  int            fulls_seen;
  int            evicted_total;
  int            cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_conf[i]  = 1'b0;
    end
    min_req[0] = tct_pkg::MIN_HITS0_RST;
    min_req[1] = '0;
    min_req[2] = '0;
    min_req[3] = '0;
    expiry_lim = tct_pkg::EXPIRY_RST;
  endfunction

  function automatic void apply_reg(logic [tct_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [tct_pkg::CFG_DATA_W-1:0]  data);
    case (idx)
      tct_pkg::CFG_MIN_HITS0: min_req[0] = data[15:0];
      tct_pkg::CFG_MIN_HITS1: min_req[1] = data[15:0];
      tct_pkg::CFG_MIN_HITS2: min_req[2] = data[15:0];
      tct_pkg::CFG_MIN_HITS3: min_req[3] = data[15:0];
      tct_pkg::CFG_EXPIRY:    expiry_lim = data;
      default: ;
    endcase
  endfunction

  // Update the predicted table for one item and return the result it should give.
  function automatic track_result_t judge_track(logic act, logic [31:0] key, logic comp,
                                                logic [3:0][3:0] hits, logic [31:0] now);
    track_result_t r;
    int            idx;
    int            free_idx;
    logic          all_met;
    logic [16:0]   sum;
    r = '0;
    if (act == tct_pkg::ACT_SWEEP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && (now < tbl_seen[i] || now - tbl_seen[i] > 32'(expiry_lim))) begin
          tbl_valid[i] = 1'b0;
          tbl_conf[i]  = 1'b0;
          r.evicted    = r.evicted + 6'd1;
        end
      end
      return r;
    end
    r.key    = key;
    idx      = -1;
    free_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (idx < 0 && tbl_key[i] == key) idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (idx < 0) begin
      if (free_idx < 0) begin
        r.full = 1'b1;
        return r;
      end
      idx            = free_idx;
      tbl_valid[idx] = 1'b1;
      tbl_key[idx]   = key;
      tbl_conf[idx]  = 1'b0;
      for (int m = 0; m < tct_pkg::MOD_SLOTS; m++) tbl_cnt[idx][m] = '0;
    end
    if (tbl_conf[idx]) begin
      r.fwd = 1'b1;
    end else if (comp) begin
      all_met = 1'b1;
      for (int m = 0; m < tct_pkg::MOD_SLOTS; m++) begin
        sum             = {1'b0, tbl_cnt[idx][m]} + 17'(hits[m]);
        tbl_cnt[idx][m] = sum[16] ? COUNT_MAX : sum[15:0];
        if (tbl_cnt[idx][m] < min_req[m]) all_met = 1'b0;
      end
      if (all_met) begin
        tbl_conf[idx] = 1'b1;
        r.fwd         = 1'b1;
        r.newc        = 1'b1;
      end
    end
    tbl_seen[idx] = now;
    return r;
  endfunction

  task automatic send_item(logic act, logic [31:0] key, logic comp, logic [3:0][3:0] hits,
                           logic [31:0] now);
    if (!no_idle && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, now, hits, comp, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), judge_track(act, key, comp, hits, now));
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tct_pkg::CFG_INDEX_W-1:0] idx,
                           logic [tct_pkg::CFG_DATA_W-1:0]  data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    track_result_t want;
    track_result_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got.key     = m_tdata[31:0];
      got.fwd     = m_tdata[32];
      got.newc    = m_tdata[33];
      got.full    = m_tdata[34];
      got.evicted = m_tdata[40:35];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.key !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, got.key);
          fail_count++;
        end
        if (got.fwd !== want.fwd) begin
          $error("forward: expected %b, got %b", want.fwd, got.fwd);
          fail_count++;
        end
        if (got.newc !== want.newc) begin
          $error("newly_confirmed: expected %b, got %b", want.newc, got.newc);
          fail_count++;
        end
        if (got.full !== want.full) begin
          $error("table_full: expected %b, got %b", want.full, got.full);
          fail_count++;
        end
        if (got.evicted !== want.evicted) begin
          $error("evicted_count: expected %0d, got %0d", want.evicted, got.evicted);
          fail_count++;
        end
        if (want.newc) confirms_seen++;
        if (want.full) fulls_seen++;
        evicted_total += want.evicted;
      end
    end
    m_tready <= no_idle || ($urandom_range(99) >= 36);
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Random observes and sweeps, keys mostly from a pool, time mostly drifting forward.
  task automatic run_traffic(int count, int pool_n, int unsigned step_max);
    logic [31:0] pool[40];
    logic [31:0] key;
    int          pick;
    for (int i = 0; i < 40; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      key  = (pick < 14) ? $urandom : pool[$urandom_range(pool_n - 1)];
      case ($urandom_range(99))
        0, 1, 2: clock_now = clock_now - $urandom_range(2 * step_max);
        3:       clock_now = $urandom;
        default: clock_now = clock_now + $urandom_range(step_max);
      endcase
      send_item(pick < 10 ? tct_pkg::ACT_SWEEP : tct_pkg::ACT_OBSERVE, key,
                $urandom_range(99) < 75, 16'($urandom), clock_now);
      // now and then let the block run dry before the next beat
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  task automatic run_phase(logic [15:0] m0, logic [15:0] m1, logic [15:0] m2, logic [15:0] m3,
                           logic [19:0] expiry, int unsigned step_max, int pool_n, int count);
    drain_results();
    write_reg(tct_pkg::CFG_MIN_HITS0, {4'($urandom_range(15)), m0});
    write_reg(tct_pkg::CFG_MIN_HITS1, {4'($urandom_range(15)), m1});
    write_reg(tct_pkg::CFG_MIN_HITS2, {4'($urandom_range(15)), m2});
    write_reg(tct_pkg::CFG_MIN_HITS3, {4'($urandom_range(15)), m3});
    write_reg(tct_pkg::CFG_EXPIRY, expiry);
    case ($urandom_range(2))
      0:       write_reg(CFG_SPARE5, 20'($urandom));
      1:       write_reg(CFG_SPARE6, 20'($urandom));
      default: write_reg(CFG_SPARE7, 20'($urandom));
    endcase
    run_traffic(count, pool_n, step_max);
  endtask

  task automatic test_directed();
    send_item(tct_pkg::ACT_OBSERVE, 32'h0000_0000, 1'b0, 16'h0000, 32'd100);
    send_item(tct_pkg::ACT_OBSERVE, 32'h0000_0000, 1'b1, 16'h0000, 32'd100);
    send_item(tct_pkg::ACT_OBSERVE, 32'h0000_0000, 1'b1, 16'hFFFF, 32'd150);
    send_item(tct_pkg::ACT_OBSERVE, 32'h0000_0000, 1'b1, 16'h0000, 32'd160);
    send_item(tct_pkg::ACT_OBSERVE, 32'hFFFF_FFFF, 1'b1, 16'h0001, 32'hFFFF_FFFF);
    // entry seen later than now goes
    send_item(tct_pkg::ACT_SWEEP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'd200);
    // age equal to the timeout stays, one past it goes
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'd5160);
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'd5161);
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'd0);
    send_item(tct_pkg::ACT_OBSERVE, 32'h0000_0000, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(tct_pkg::ACT_OBSERVE, 32'hAAAA_5555, 1'b1, 16'h8421, 32'h5555_AAAA);
    send_item(tct_pkg::ACT_OBSERVE, 32'h1234_5678, 1'b1, 16'hF0F0, 32'hFFFF_FFFE);
    send_item(tct_pkg::ACT_OBSERVE, 32'h5555_AAAA, 1'b1, 16'h1248, 32'hFFFF_FFFE);
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'hFFFF_FFFF);
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_table_full();
    logic [31:0] keys[ENTRIES + 1];
    for (int i = 0; i <= ENTRIES; i++) keys[i] = {8'(i), 24'($urandom)};
    for (int i = 0; i <= ENTRIES; i++)
      send_item(tct_pkg::ACT_OBSERVE, keys[i], 1'b1, 16'($urandom), 32'd1000 + i);
    send_item(tct_pkg::ACT_OBSERVE, keys[0], 1'b1, 16'h0003, 32'd1100);
    send_item(tct_pkg::ACT_OBSERVE, keys[ENTRIES], 1'b0, 16'h0, 32'd1101);
    // every entry is stale now, so the whole table goes
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'h1000_0000);
    send_item(tct_pkg::ACT_OBSERVE, keys[ENTRIES], 1'b1, 16'h0001, 32'h1000_0000);
    clock_now = 32'h1000_0000;
  endtask

  // Climb one track's counters toward a large minimum, then lower it so the track confirms.
  task automatic test_high_minimum();
    logic [31:0] key;
    key = $urandom;
    drain_results();
    write_reg(tct_pkg::CFG_MIN_HITS0, 20'h0FFFF);
    write_reg(tct_pkg::CFG_MIN_HITS1, 20'h00001);
    write_reg(tct_pkg::CFG_MIN_HITS2, 20'h00000);
    write_reg(tct_pkg::CFG_MIN_HITS3, 20'h00000);
    no_idle = 1'b1;
    send_item(tct_pkg::ACT_SWEEP, 32'h0, 1'b0, 16'h0, 32'hFFFF_0000);
    for (int n = 0; n < 60; n++)
      send_item(tct_pkg::ACT_OBSERVE, key, 1'b1, 16'h00FF, 32'd7);
    drain_results();
    write_reg(tct_pkg::CFG_MIN_HITS0, 20'd900);
    send_item(tct_pkg::ACT_OBSERVE, key, 1'b1, 16'h001F, 32'd7);
    send_item(tct_pkg::ACT_OBSERVE, key, 1'b0, 16'h0000, 32'd8);
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_config_phases();
    run_phase(16'd1, 16'd0, 16'd0, 16'd0, 20'd5000, 900, 12, 170);
    run_phase(16'd3, 16'd2, 16'd1, 16'd4, 20'd2000, 500, 40, 170);
    run_phase(16'd0, 16'd0, 16'd0, 16'd0, 20'd0, 2, 10, 150);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 200000, 40, 150);
    no_idle = 1'b1;
    run_phase(16'd10, 16'd0, 16'd7, 16'd0, 20'd1000000, 150000, 20, 150);
    no_idle = 1'b0;
    run_phase(16'd2, 16'd2, 16'd2, 16'd2, 20'd300, 80, 16, 170);
    drain_results();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tuser    = 1'b0;
    s_tdata    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    clock_now  = 32'd0;
    no_idle    = 1'b0;
    fail_count = 0;
    reset_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_config_phases();
    test_high_minimum();

    $display("Sent %0d items (observes and sweeps), checked %0d results.",
             items_sent, results_seen);
    $display("Saw %0d confirmations, %0d full-table rejects, %0d evictions across several register settings.",
             confirms_seen, fulls_seen, evicted_total);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tct_pkg.sv
hdl/tct_ram.sv
hdl/tct_cmp_unit.sv
hdl/tct_count_upd.sv
hdl/track_confirmation_table.sv
hdl/tct_checker.sv
tb/tb_track_confirmation_table.sv
